/* src/mtw_pkg.sv */
// Shared types, constants and helper functions for the MT19937 word generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mtw_pkg;

	localparam int unsigned STATE_WORDS   = 624;
	localparam int unsigned MIDDLE_OFFSET = 397;

	typedef logic [31:0] word_t;
	typedef logic [9:0]  addr_t;
	typedef logic [2:0]  paddr_t;

	localparam word_t TWIST_MATRIX = 32'h9908_b0df;
	localparam word_t HIGH_BIT     = 32'h8000_0000;
	localparam word_t LOW_BITS     = 32'h7fff_ffff;
	localparam word_t TEMPER_B     = 32'h9d2c_5680;
	localparam word_t TEMPER_C     = 32'hefc6_0000;
	localparam word_t SEED_MULT    = 32'd69069;
	localparam word_t SEED_RESET   = 32'd4357;

	localparam addr_t       FIRST_ADDR   = 10'd0;
	localparam addr_t       LAST_ADDR    = 10'(STATE_WORDS - 1);
	localparam logic [9:0]  IDX_FULL     = 10'(STATE_WORDS);
	localparam logic [9:0]  IDX_UNSEEDED = 10'(STATE_WORDS + 1);

	// register byte addresses
	localparam paddr_t ADDR_SEED_VALUE = 3'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_TW_PRIME,
		ST_TW_LOAD,
		ST_TW_RUN,
		ST_READ,
		ST_LOAD
	} state_t;

	function automatic addr_t nxt_addr(input addr_t k);
		return (k == LAST_ADDR) ? FIRST_ADDR : addr_t'(k + 10'd1);
	endfunction

	function automatic addr_t far_addr(input addr_t k);
		logic [10:0] s;
		s = {1'b0, k} + 11'(MIDDLE_OFFSET);
		if (s >= 11'(STATE_WORDS)) begin
			s = s - 11'(STATE_WORDS);
		end
		return s[9:0];
	endfunction

	function automatic word_t mix_pair(input word_t upper, input word_t lower, input word_t far);
		word_t y;
		y = (upper & HIGH_BIT) | (lower & LOW_BITS);
		return far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
	endfunction

	function automatic word_t temper(input word_t w);
		word_t y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

`default_nettype wire

/* src/mt19937_word_generator_unit.sv */
// A draw reads its table word, then registers the tempered word once the output is free.
// Throughput: one word per cycle while the index stays below 624 and the output is taken.
// Twist pass: every 624 words, one word per cycle through a 2-read-port table.
// Seeding (first request after reset, or reseed_first): fill all 624 words, then twist.
// Reset: index marks the table unseeded, seed = 4357; the table itself is not cleared.
// Depends on mtw_pkg and mtw_cfg_regs.
`timescale 1ns / 1ps
`default_nettype none

module mt19937_word_generator_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  logic            reseed_first,
	output logic            word_valid,
	input  logic            word_ready,
	output mtw_pkg::word_t  random_word,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  mtw_pkg::paddr_t paddr,
	input  mtw_pkg::word_t  pwdata,
	output mtw_pkg::word_t  prdata,
	output logic            pready
);
	import mtw_pkg::*;

	state_t     state_q, state_d;
	addr_t      k_q;
	logic [9:0] idx_q;
	word_t      x_q, cur_q, out_q;
	logic       out_valid_q;
	word_t      seed;

	word_t table_mem [STATE_WORDS];
	word_t rd_a_q, rd_b_q;

	logic  rd_en_a, rd_en_b, wr_en;
	addr_t addr_a, addr_b, wr_addr;
	word_t wr_data;

	logic       slot_free, req_fire, load_out;
	logic [9:0] idx_after;
	logic       need_seed, need_twist;

	mtw_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.seed_value (seed)
	);

	assign slot_free  = !out_valid_q || word_ready;
	assign req_ready  = (state_q == ST_IDLE) || ((state_q == ST_LOAD) && slot_free);
	assign req_fire   = req_valid && req_ready;
	// in LOAD the word being handed over has already used idx_q
	assign idx_after  = (state_q == ST_LOAD) ? idx_q + 10'd1 : idx_q;
	assign need_seed  = reseed_first || (idx_after >= IDX_UNSEEDED);
	assign need_twist = idx_after >= IDX_FULL;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					state_d = need_seed ? ST_FILL : (need_twist ? ST_TW_PRIME : ST_LOAD);
				end
			end
			ST_FILL: begin
				if (k_q == LAST_ADDR) state_d = ST_TW_PRIME;
			end
			ST_TW_PRIME: state_d = ST_TW_LOAD;
			ST_TW_LOAD:  state_d = ST_TW_RUN;
			ST_TW_RUN: begin
				if (k_q == LAST_ADDR) state_d = ST_READ;
			end
			ST_READ: state_d = ST_LOAD;
			ST_LOAD: begin
				if (slot_free) begin
					if (req_fire) begin
						state_d = need_seed ? ST_FILL : (need_twist ? ST_TW_PRIME : ST_LOAD);
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// table port controls
	always_comb begin
		rd_en_a  = 1'b0;
		rd_en_b  = 1'b0;
		addr_a   = k_q;
		addr_b   = k_q;
		wr_en    = 1'b0;
		wr_addr  = k_q;
		wr_data  = x_q;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rd_en_a = req_fire && !need_seed && !need_twist;
				addr_a  = idx_after;
			end
			ST_FILL: begin
				wr_en = 1'b1;
			end
			ST_TW_PRIME: begin
				rd_en_a = 1'b1;
				addr_a  = FIRST_ADDR;
			end
			ST_TW_LOAD: begin
				rd_en_a = 1'b1;
				rd_en_b = 1'b1;
				addr_a  = nxt_addr(k_q);
				addr_b  = far_addr(k_q);
			end
			ST_TW_RUN: begin
				// in-place update; taps past the wrap see words already twisted
				wr_en   = 1'b1;
				wr_data = mix_pair(cur_q, rd_a_q, rd_b_q);
				rd_en_a = 1'b1;
				rd_en_b = 1'b1;
				addr_a  = nxt_addr(nxt_addr(k_q));
				addr_b  = far_addr(nxt_addr(k_q));
			end
			ST_READ: begin
				rd_en_a = 1'b1;
				addr_a  = idx_q;
			end
			ST_LOAD: begin
				load_out = slot_free;
				rd_en_a  = req_fire && !need_seed && !need_twist;
				addr_a   = idx_after;
			end
			default: begin
				rd_en_a = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) table_mem[wr_addr] <= wr_data;
		if (rd_en_a) rd_a_q <= table_mem[addr_a];
		if (rd_en_b) rd_b_q <= table_mem[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= FIRST_ADDR;
			idx_q       <= IDX_UNSEEDED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_FILL) || (state_q == ST_TW_RUN)) begin
				k_q <= nxt_addr(k_q);
			end
			if ((state_q == ST_FILL) && (k_q == LAST_ADDR)) begin
				idx_q <= IDX_FULL;
			end else if ((state_q == ST_TW_RUN) && (k_q == LAST_ADDR)) begin
				idx_q <= '0;
			end else if (load_out) begin
				idx_q <= idx_q + 10'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (word_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire && need_seed) begin
			x_q <= seed;
		end else if (state_q == ST_FILL) begin
			x_q <= x_q * SEED_MULT;
		end
		if ((state_q == ST_TW_LOAD) || (state_q == ST_TW_RUN)) begin
			cur_q <= rd_a_q;
		end
		if (load_out) begin
			out_q <= temper(rd_a_q);
		end
	end

	assign word_valid  = out_valid_q;
	assign random_word = out_q;

endmodule

`default_nettype wire

/* src/mtw_cfg_regs.sv */
// APB-style register block holding the seed register.
// Depends on mtw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtw_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  mtw_pkg::paddr_t paddr,
	input  mtw_pkg::word_t  pwdata,
	output mtw_pkg::word_t  prdata,
	output logic           pready,
	output mtw_pkg::word_t  seed_value
);
	import mtw_pkg::*;

	word_t seed_q;
	logic  hit_seed;

	assign hit_seed   = (paddr == ADDR_SEED_VALUE);
	assign pready     = 1'b1;
	assign prdata     = hit_seed ? seed_q : '0;
	assign seed_value = seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (psel && penable && pwrite && pready && hit_seed) begin
			seed_q <= pwdata;
		end
	end

endmodule

`default_nettype wire

/* src/mtw_checker.sv */
// Port-level checks for the MT19937 word generator, bound to the top level.
// Depends on mtw_pkg and mt19937_word_generator_unit.
`timescale 1ns / 1ps
`default_nettype none

module mtw_checker (
	input wire            clk,
	input wire            arst_n,
	input wire            req_valid,
	input wire            req_ready,
	input wire            word_valid,
	input wire            word_ready,
	input mtw_pkg::word_t random_word,
	input wire            psel,
	input wire            pready
);
	import mtw_pkg::*;

	// transfers accepted on the request side and not yet delivered
	logic [1:0] pending_q;
	logic       req_xfer, word_xfer;

	assign req_xfer  = req_valid && req_ready;
	assign word_xfer = word_valid && word_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (req_xfer && !word_xfer) begin
			pending_q <= pending_q + 2'd1;
		end else if (word_xfer && !req_xfer) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_ready |=> word_valid && $stable(random_word))
		else $error("result dropped or changed while stalled");

	a_no_spurious_word: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid |-> pending_q != 2'd0)
		else $error("result shown with no outstanding request");

	a_bounded_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two requests in flight");

	a_one_word_per_req: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 2'd2 |-> !req_ready || word_ready)
		else $error("request taken with no room for its result");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("register port inserted a wait state");

endmodule

bind mt19937_word_generator_unit mtw_checker u_mtw_checker (.*);

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for mt19937_word_generator_unit: random-word requests, APB seed writes.
// Depends on mtw_pkg (types and register address) and the RTL under src/.
`timescale 1ns / 1ps

module tb;
	import mtw_pkg::*;

	localparam int     WATCHDOG_LIMIT = 8000;
	localparam word_t  POWER_ON_SEED  = 32'd4357;
	localparam word_t  LCG_MUL        = 32'd69069;
	localparam word_t  MT_MATRIX_A    = 32'h9908_b0df;
	localparam word_t  MT_UPPER       = 32'h8000_0000;
	localparam word_t  MT_LOWER       = 32'h7fff_ffff;
	localparam word_t  MT_MASK_B      = 32'h9d2c_5680;
	localparam word_t  MT_MASK_C      = 32'hefc6_0000;
	localparam int     MT_MID         = 397;
	localparam paddr_t ADDR_UNMAPPED  = 3'd4;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   req_valid;
	logic   req_ready;
	logic   reseed_first;
	logic   word_valid;
	logic   word_ready;
	word_t  random_word;
	logic   psel;
	logic   penable;
	logic   pwrite;
	paddr_t paddr;
	word_t  pwdata;
	word_t  prdata;
	logic   pready;

	// predictor state
	word_t mt_table [STATE_WORDS];
	int    mt_index;
	word_t mt_seed;
	word_t expected_words [$];

	int errors        = 0;
	int n_requests    = 0;
	int n_reseeds     = 0;
	int words_checked = 0;
	int n_seeds       = 0;
	int idle_cycles   = 0;
	int rx_hold       = 0;
	int rx_stall      = 0;
	bit tx_idle_on    = 1'b1;
	bit rx_idle_on    = 1'b1;

	mt19937_word_generator_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.reseed_first(reseed_first),
		.word_valid(word_valid),
		.word_ready(word_ready),
		.random_word(random_word),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	function automatic void load_table(input word_t s);
		mt_table[0] = s;
		for (int i = 1; i < STATE_WORDS; i++) begin
			mt_table[10'(i)] = mt_table[10'(i - 1)] * LCG_MUL;
		end
		mt_index = STATE_WORDS;
	endfunction

	// in-place regeneration: late taps see words already updated this pass
	function automatic void regenerate_table();
		word_t y;
		for (int k = 0; k < STATE_WORDS; k++) begin
			y = (mt_table[10'(k)] & MT_UPPER)
				| (mt_table[10'((k + 1) % STATE_WORDS)] & MT_LOWER);
			mt_table[10'(k)] = mt_table[10'((k + MT_MID) % STATE_WORDS)] ^ (y >> 1)
				^ (y[0] ? MT_MATRIX_A : 32'h0);
		end
		mt_index = 0;
	endfunction

	function automatic word_t tempered(input word_t w);
		word_t y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & MT_MASK_B);
		y = y ^ ((y << 15) & MT_MASK_C);
		return y ^ (y >> 18);
	endfunction

	function automatic void predict_word(input bit reseed);
		if (reseed || mt_index > STATE_WORDS) begin
			load_table(mt_seed);
		end
		if (mt_index == STATE_WORDS) begin
			regenerate_table();
		end
		expected_words.push_back(tempered(mt_table[10'(mt_index)]));
		mt_index++;
	endfunction

	task automatic report_mismatch(input string what, input word_t got, input word_t want);
		$display("%0t mismatch: %s, got %08h want %08h", $realtime, what, got, want);
		errors++;
	endtask

	// one request transfer; optional idle burst first
	task automatic send_req(input bit reseed);
		int gap;
		gap = (tx_idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
		@(negedge clk);
		if (gap != 0) begin
			req_valid    <= 1'b0;
			reseed_first <= 1'($urandom_range(0, 1));
			repeat (gap) @(negedge clk);
		end
		req_valid    <= 1'b1;
		reseed_first <= reseed;
		do @(posedge clk); while (!req_ready);
		predict_word(reseed);
		n_requests++;
		if (reseed) begin
			n_reseeds++;
		end
	endtask

	// reseed_per_k: chance of a reseed in thousandths
	task automatic send_burst(input int count, input int reseed_per_k);
		for (int n = 0; n < count; n++) begin
			send_req($urandom_range(0, 999) < reseed_per_k);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input paddr_t addr, input word_t data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_SEED_VALUE) begin
			mt_seed = data;
		end
	endtask

	task automatic apb_read_check(input paddr_t addr, input word_t want);
		word_t got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== want) begin
			report_mismatch("seed register read-back", got, want);
		end
	endtask

	task automatic set_seed(input word_t s);
		wait_drained();
		apb_write(ADDR_SEED_VALUE, s);
		apb_read_check(ADDR_SEED_VALUE, s);
		n_seeds++;
	endtask

	task automatic test_first_draw_after_reset();
		// the first request seeds itself from the reset value
		apb_read_check(ADDR_SEED_VALUE, POWER_ON_SEED);
		send_burst(4, 0);
	endtask

	task automatic test_zero_seed();
		set_seed(32'h0000_0000);
		send_req(1'b1);
		send_burst(3, 0);
	endtask

	task automatic test_seed_extremes();
		set_seed(32'hffff_ffff);
		send_req(1'b1);
		send_burst(2, 0);
		set_seed(32'h0000_0001);
		send_req(1'b1);
		send_burst(2, 0);
	endtask

	task automatic test_unmapped_register();
		// write to a hole in the map must leave the seed alone
		wait_drained();
		apb_write(ADDR_UNMAPPED, $urandom());
		apb_read_check(ADDR_SEED_VALUE, mt_seed);
		send_req(1'b1);
		send_req(1'b0);
	endtask

	task automatic test_reseed_mid_stream();
		set_seed(POWER_ON_SEED);
		send_burst(2, 0);
		send_req(1'b1);
		send_req(1'b0);
	endtask

	task automatic test_long_stream();
		// long enough to cross a table regeneration
		set_seed($urandom());
		send_req(1'b1);
		send_burst(660, 0);
	endtask

	task automatic test_reseed_mix();
		word_t s;
		for (int p = 0; p < 4; p++) begin
			case ($urandom_range(0, 3))
				0: s = 32'hffff_ffff;
				1: s = 32'h8000_0000;
				default: s = $urandom();
			endcase
			set_seed(s);
			send_burst(30, 120);
		end
	endtask

	task automatic test_output_backpressure();
		wait_drained();
		rx_hold = 300;
		send_burst(40, 0);
	endtask

	task automatic test_back_to_back();
		wait_drained();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		send_burst(60, 0);
	endtask

	// receiver: random stall bursts, or one long hold-off on request
	initial begin
		word_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold != 0) begin
				rx_stall = rx_hold;
				rx_hold  = 0;
			end else if (rx_stall == 0 && rx_idle_on && $urandom_range(0, 9) == 0) begin
				rx_stall = $urandom_range(1, 14);
			end
			if (rx_stall != 0) begin
				word_ready <= 1'b0;
				rx_stall--;
			end else begin
				word_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_words
		word_t want;
		if (arst_n && word_valid && word_ready) begin
			words_checked++;
			if (expected_words.size() == 0) begin
				report_mismatch("word with no request pending", random_word, 32'h0);
			end else begin
				want = expected_words.pop_front();
				if (random_word !== want) begin
					report_mismatch("random_word", random_word, want);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (word_valid && word_ready)
				|| (psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d words outstanding",
					WATCHDOG_LIMIT, expected_words.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		reseed_first = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		mt_seed      = POWER_ON_SEED;
		mt_index     = STATE_WORDS + 1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_first_draw_after_reset();
		test_zero_seed();
		test_seed_extremes();
		test_unmapped_register();
		test_reseed_mid_stream();
		test_long_stream();
		test_reseed_mix();
		test_output_backpressure();
		test_back_to_back();

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Covered %0d requests (%0d with reseed) over %0d seed settings;", n_requests,
			n_reseeds, n_seeds);
		$display("%0d words checked, %0d mismatches.", words_checked, errors);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
